// ===== sv/dbpr_pkg.sv =====
// shared types, constants and widths for the depth buoyancy piston regulator
// no dependencies; imported by every module of the block

package dbpr_pkg;

  // fixed-point format
  localparam int FRAC_BITS  = 16;   // fractional bits of signed q values
  localparam int STEP_LIMIT = 200;  // accumulator step window in ticks
  localparam int BUOY_FRAC  = 40;   // fractional bits of the buoyancy gain
  localparam int BUOY_SH    = BUOY_FRAC - FRAC_BITS;

  // field widths
  localparam int VAL_W    = 32;
  localparam int POS_W    = 16;
  localparam int GAIN_W   = 32;
  localparam int OFFS_W   = 16;
  localparam int MAXD_W   = 15;
  localparam int CFG_IDX_W = 3;

  // product datapath widths
  localparam int CAP_LOG = 40;                 // products saturate at 2^40
  localparam int PROD_W  = CAP_LOG + 1;
  localparam int A_W     = 42;                 // widest multiplicand (|s|)
  localparam int HI_W    = A_W - 32;
  localparam int P32_W   = HI_W + 33;
  localparam int S_W     = A_W + 1;
  localparam int ACC_W   = MAXD_W + 1 + FRAC_BITS;
  localparam int SUM_W   = ((ACC_W > PROD_W + 1) ? ACC_W : PROD_W + 1) + 1;
  localparam int TOT_W   = FRAC_BITS + 18;

  // register reset values
  localparam logic [GAIN_W-1:0] BUOY_RST = GAIN_W'(1544300);
  localparam logic [GAIN_W-1:0] DRAG_RST = GAIN_W'(2621);
  localparam logic [GAIN_W-1:0] VELG_RST = GAIN_W'(13107200);
  localparam logic [GAIN_W-1:0] KGN_RST  = GAIN_W'(3277);
  localparam logic [OFFS_W-1:0] OFFS_RST = OFFS_W'(1040);
  localparam logic [MAXD_W-1:0] MAXD_RST = MAXD_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUOYANCY_GAIN   = 3'd0,
    CFG_DRAG_GAIN       = 3'd1,
    CFG_VELOCITY_GAIN   = 3'd2,
    CFG_OVERALL_GAIN    = 3'd3,
    CFG_POSITION_OFFSET = 3'd4,
    CFG_MAX_DELTA       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] buoyancy_gain;
    logic [GAIN_W-1:0] drag_gain;
    logic [GAIN_W-1:0] velocity_gain;
    logic [GAIN_W-1:0] overall_gain;
    logic [OFFS_W-1:0] position_offset;
    logic [MAXD_W-1:0] max_delta;
  } cfg_t;

  // which product the shared multiplier is working on
  typedef enum logic [2:0] {
    OP_VV,
    OP_DRAG,
    OP_VEL,
    OP_BUOY,
    OP_CMD
  } mul_op_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_LO,
    DP_MUL_HI,
    DP_MUL_FIN,
    DP_SURF_A,
    DP_SURF_B,
    DP_ACC,
    DP_CLAMP,
    DP_OUT_REG,
    DP_OUT_IDLE
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    mul_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic enabled;   // latched set point is positive
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_FIN,
    ST_SURF_A,
    ST_SURF_B,
    ST_ACC,
    ST_CLAMP,
    ST_OUT_ON,
    ST_OUT_OFF
  } state_e;

endpackage

// ===== sv/depth_buoyancy_piston_regulator_top.sv =====
// top level of the depth buoyancy piston regulator
// depends on dbpr_pkg, dbpr_cfg, dbpr_ctrl and dbpr_datapath
//
// usage
// - one item on the slave stream is one control tick: depth, vertical speed,
//   piston position and depth set point
// - one item leaves on the master stream per input item: the commanded piston
//   position in tdata and the regulating flag in tuser
// - the configuration channel writes one gain, offset or limit per handshake;
//   cfg_ready_o is always high; writes must be made while the block is idle,
//   which the block itself does not check
// - a regulated item holds the block until its result is loaded:
//   five products run through one shared 32x32 multiplier, each as low half,
//   high half, then scale and saturate, plus the surface sum, the
//   accumulator step, the clamp and the output load
// - an item with a set point at or below zero skips the products and returns 0
// reset
// - registers return to their defaults, the tick accumulator clears to zero
// stall
// - a result waits in the output register; the next item is still accepted,
//   and its own result waits until the slot frees up

module depth_buoyancy_piston_regulator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] depth_now, [63:32] vertical_speed, [79:64] piston_ticks,
  // [111:80] target_depth
  input  logic [111:0]                    s_axis_tdata,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] piston_target
  output logic [15:0]                     m_axis_tdata,
  // [0] regulating
  output logic                            m_axis_tuser,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dbpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dbpr_pkg::GAIN_W-1:0]     cfg_data_i
);
  import dbpr_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // unpack the input item
  logic signed [VAL_W-1:0] depth_now, vertical_speed, target_depth;
  logic        [POS_W-1:0] piston_ticks;

  assign depth_now      = s_axis_tdata[31:0];
  assign vertical_speed = s_axis_tdata[63:32];
  assign piston_ticks   = s_axis_tdata[79:64];
  assign target_depth   = s_axis_tdata[111:80];

  dbpr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer: handshakes and step order
  dbpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic, accumulator and result register
  dbpr_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .depth_now_i      (depth_now),
    .vertical_speed_i (vertical_speed),
    .piston_ticks_i   (piston_ticks),
    .target_depth_i   (target_depth),
    .piston_target_o  (m_axis_tdata),
    .regulating_o     (m_axis_tuser)
  );

  // a result that is not regulating always commands zero ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("idle result with nonzero piston target");

  // the block is busy in the cycle after it takes an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // a new result is only loaded into a free output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.cmd == DP_OUT_REG || cmd.cmd == DP_OUT_IDLE) |->
      (!m_axis_tvalid || m_axis_tready))
    else $error("output overwritten while stalled");

endmodule

// ===== sv/dbpr_cfg.sv =====
// configuration register bank of the depth regulator
// depends on dbpr_pkg

module dbpr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dbpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dbpr_pkg::GAIN_W-1:0]    cfg_data_i,
  output dbpr_pkg::cfg_t                 cfg_o
);
  import dbpr_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buoyancy_gain   <= BUOY_RST;
      cfg_q.drag_gain       <= DRAG_RST;
      cfg_q.velocity_gain   <= VELG_RST;
      cfg_q.overall_gain    <= KGN_RST;
      cfg_q.position_offset <= OFFS_RST;
      cfg_q.max_delta       <= MAXD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BUOYANCY_GAIN:   cfg_q.buoyancy_gain   <= cfg_data_i;
        CFG_DRAG_GAIN:       cfg_q.drag_gain       <= cfg_data_i;
        CFG_VELOCITY_GAIN:   cfg_q.velocity_gain   <= cfg_data_i;
        CFG_OVERALL_GAIN:    cfg_q.overall_gain    <= cfg_data_i;
        CFG_POSITION_OFFSET: cfg_q.position_offset <= cfg_data_i[OFFS_W-1:0];
        CFG_MAX_DELTA:       cfg_q.max_delta       <= cfg_data_i[MAXD_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

endmodule

// ===== sv/dbpr_ctrl.sv =====
// sequencer of the depth regulator: walks the datapath through the products
// depends on dbpr_pkg

module dbpr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  dbpr_pkg::dp_status_t status_i,
  output dbpr_pkg::ctrl_cmd_t  cmd_o
);
  import dbpr_pkg::*;

  state_e  state_q, state_d;
  mul_op_e op_q, op_d;
  logic    valid_q, valid_d;
  logic    slot_free;

  assign slot_free   = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_VV;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = 1'b0;
    cmd_o.cmd  = DP_NOP;
    cmd_o.op   = op_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cmd = DP_LOAD;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.enabled) begin
          op_d    = OP_VV;
          state_d = ST_MUL_LO;
        end else begin
          state_d = ST_OUT_OFF;
        end
      end
      ST_MUL_LO: begin
        cmd_o.cmd = DP_MUL_LO;
        state_d   = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.cmd = DP_MUL_HI;
        state_d   = ST_MUL_FIN;
      end
      ST_MUL_FIN: begin
        cmd_o.cmd = DP_MUL_FIN;
        unique case (op_q)
          OP_VV: begin
            op_d    = OP_DRAG;
            state_d = ST_MUL_LO;
          end
          OP_DRAG: begin
            op_d    = OP_VEL;
            state_d = ST_MUL_LO;
          end
          OP_VEL: begin
            op_d    = OP_BUOY;
            state_d = ST_MUL_LO;
          end
          OP_BUOY: state_d = ST_SURF_A;
          OP_CMD:  state_d = ST_ACC;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SURF_A: begin
        cmd_o.cmd = DP_SURF_A;
        state_d   = ST_SURF_B;
      end
      ST_SURF_B: begin
        cmd_o.cmd = DP_SURF_B;
        op_d      = OP_CMD;
        state_d   = ST_MUL_LO;
      end
      ST_ACC: begin
        cmd_o.cmd = DP_ACC;
        state_d   = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.cmd = DP_CLAMP;
        state_d   = ST_OUT_ON;
      end
      ST_OUT_ON: begin
        if (slot_free) begin
          cmd_o.cmd = DP_OUT_REG;
          state_d   = ST_IDLE;
        end
      end
      ST_OUT_OFF: begin
        if (slot_free) begin
          cmd_o.cmd = DP_OUT_IDLE;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output slot: set on load, cleared when the item is taken
  always_comb begin
    valid_d = valid_q;
    if (cmd_o.cmd == DP_OUT_REG || cmd_o.cmd == DP_OUT_IDLE) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

endmodule

// ===== sv/dbpr_datapath.sv =====
// datapath of the depth regulator: shared 32x32 multiplier, surface sum,
// tick accumulator and output register; depends on dbpr_pkg

module dbpr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dbpr_pkg::cfg_t                cfg_i,
  input  dbpr_pkg::ctrl_cmd_t           cmd_i,
  output dbpr_pkg::dp_status_t          status_o,
  input  logic signed [dbpr_pkg::VAL_W-1:0] depth_now_i,
  input  logic signed [dbpr_pkg::VAL_W-1:0] vertical_speed_i,
  input  logic        [dbpr_pkg::POS_W-1:0] piston_ticks_i,
  input  logic signed [dbpr_pkg::VAL_W-1:0] target_depth_i,
  output logic        [dbpr_pkg::POS_W-1:0] piston_target_o,
  output logic                              regulating_o
);
  import dbpr_pkg::*;

  localparam logic [PROD_W-1:0] PROD_CAP = PROD_W'(1) << CAP_LOG;
  localparam logic signed [SUM_W-1:0] STEP_LIM_Q = SUM_W'(STEP_LIMIT) << FRAC_BITS;
  localparam logic [TOT_W-1:0] HALF_Q = TOT_W'(1) << (FRAC_BITS - 1);
  localparam logic [TOT_W-1:0] POS_MAX = TOT_W'({POS_W{1'b1}});

  // latched item
  logic signed [VAL_W-1:0] depth_q, target_q;
  logic                    vneg_q;
  logic [VAL_W-1:0]        vmag_q;
  logic [POS_W-1:0]        pos_q;

  // products and intermediate sums
  logic [63:0]             lo_q;
  logic [HI_W+31:0]        hi_q;
  logic [PROD_W-1:0]       vv_q, dterm_q, kterm_q, bterm_q, cmag_q;
  logic signed [S_W-1:0]   e_q, s_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [POS_W-1:0]        res_target_q;
  logic                    res_reg_q;

  logic [VAL_W-1:0]        vmag_in;
  logic [A_W-1:0]          a_sel, smag;
  logic [GAIN_W-1:0]       b_sel;
  logic [31:0]             mul_x;
  logic [63:0]             prod;
  logic [P32_W-1:0]        p32;
  logic [P32_W+31:0]       full;
  logic                    sat_f, sat_b;
  logic [PROD_W-1:0]       fin_res;
  logic [PROD_W:0]         dk;
  logic signed [SUM_W-1:0] acc_x, cmd_x, sum;
  logic                    step_ok;
  logic signed [ACC_W-1:0] lim;
  logic signed [TOT_W-1:0] total;
  logic [TOT_W-1:0]        rnd, rnd_sh;
  logic [POS_W-1:0]        out_val;

  assign status_o.enabled = (target_q > 0);
  assign piston_target_o  = res_target_q;
  assign regulating_o     = res_reg_q;

  assign vmag_in = vertical_speed_i[VAL_W-1] ? VAL_W'(-vertical_speed_i)
                                             : VAL_W'(vertical_speed_i);
  assign smag    = s_q[S_W-1] ? A_W'(-s_q) : A_W'(s_q);

  // operand selection for the shared multiplier
  always_comb begin
    unique case (cmd_i.op)
      OP_VV: begin
        a_sel = A_W'(vmag_q);
        b_sel = vmag_q;
      end
      OP_DRAG: begin
        a_sel = A_W'(vv_q);
        b_sel = cfg_i.drag_gain;
      end
      OP_VEL: begin
        a_sel = A_W'(vmag_q);
        b_sel = cfg_i.velocity_gain;
      end
      OP_BUOY: begin
        a_sel = A_W'(pos_q);
        b_sel = cfg_i.buoyancy_gain;
      end
      OP_CMD: begin
        a_sel = smag;
        b_sel = cfg_i.overall_gain;
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  // low half of the multiplicand first, then the high bits
  assign mul_x = (cmd_i.cmd == DP_MUL_HI) ? 32'(a_sel[A_W-1:32]) : a_sel[31:0];
  assign prod  = mul_x * b_sel;

  // recombine, truncate to the target scale and saturate
  assign p32   = P32_W'(hi_q) + P32_W'(lo_q[63:32]);
  assign full  = {p32, lo_q[31:0]};
  assign sat_f = (p32 >> (FRAC_BITS + 8)) != '0;
  assign sat_b = (p32 >> (BUOY_SH + 8)) != '0;
  always_comb begin
    if (cmd_i.op == OP_BUOY) begin
      fin_res = sat_b ? PROD_CAP : PROD_W'(full >> BUOY_SH);
    end else begin
      fin_res = sat_f ? PROD_CAP : PROD_W'(full >> FRAC_BITS);
    end
  end

  // accumulator step and window check
  assign dk      = (PROD_W + 1)'(dterm_q) + (PROD_W + 1)'(kterm_q);
  assign acc_x   = SUM_W'(acc_q);
  assign cmd_x   = s_q[S_W-1] ? signed'(SUM_W'(cmag_q)) : -signed'(SUM_W'(cmag_q));
  assign sum     = acc_x + cmd_x;
  assign step_ok = (sum < STEP_LIM_Q) && (sum > -STEP_LIM_Q);
  assign lim     = signed'(ACC_W'({cfg_i.max_delta, {FRAC_BITS{1'b0}}}));

  // rounded, saturated output
  assign total  = signed'(TOT_W'(acc_q) +
                          TOT_W'({cfg_i.position_offset, {FRAC_BITS{1'b0}}}));
  assign rnd    = TOT_W'(total) + HALF_Q;
  assign rnd_sh = rnd >> FRAC_BITS;
  always_comb begin
    if (total <= 0) begin
      out_val = '0;
    end else if (rnd_sh > POS_MAX) begin
      out_val = {POS_W{1'b1}};
    end else begin
      out_val = rnd_sh[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.cmd)
      DP_LOAD: begin
        depth_q  <= depth_now_i;
        target_q <= target_depth_i;
        vneg_q   <= vertical_speed_i[VAL_W-1];
        vmag_q   <= vmag_in;
        pos_q    <= piston_ticks_i;
      end
      DP_MUL_LO: lo_q <= prod;
      DP_MUL_HI: hi_q <= prod[HI_W+31:0];
      DP_MUL_FIN: begin
        unique case (cmd_i.op)
          OP_VV:   vv_q    <= fin_res;
          OP_DRAG: dterm_q <= fin_res;
          OP_VEL:  kterm_q <= fin_res;
          OP_BUOY: bterm_q <= fin_res;
          OP_CMD:  cmag_q  <= fin_res;
          default: ;
        endcase
      end
      DP_SURF_A: e_q <= S_W'(depth_q) - S_W'(target_q) + signed'(S_W'(bterm_q));
      DP_SURF_B: begin
        if (vneg_q) begin
          s_q <= e_q - signed'(S_W'(dk));
        end else begin
          s_q <= e_q + signed'(S_W'(dk));
        end
      end
      DP_OUT_REG: begin
        res_target_q <= out_val;
        res_reg_q    <= 1'b1;
      end
      DP_OUT_IDLE: begin
        res_target_q <= '0;
        res_reg_q    <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.cmd == DP_ACC) begin
      if (step_ok) begin
        acc_q <= sum[ACC_W-1:0];
      end
    end else if (cmd_i.cmd == DP_CLAMP) begin
      if (acc_q > lim) begin
        acc_q <= lim;
      end else if (acc_q < -lim) begin
        acc_q <= -lim;
      end
    end
  end

endmodule

// ===== verif/tb_depth_buoyancy_piston_regulator_top.sv =====
// testbench for depth_buoyancy_piston_regulator_top: streams control ticks through the
// block and checks every piston command against an in-bench fixed-point predictor
// depends on dbpr_pkg and the block's rtl only
`timescale 1ns / 1ps

module tb_depth_buoyancy_piston_regulator_top;
  import dbpr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;  // unmapped register slots
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef enum int {
    DRAIN_FREE,
    DRAIN_PATTERN,
    DRAIN_SLOW,
    DRAIN_COIN
  } drain_mode_e;

  // predicts piston commands and holds the ones still owed by the block
  class piston_cmd_board;
    typedef struct {
      logic [15:0] piston_target;
      logic        regulating;
    } piston_cmd_t;

    logic [GAIN_W-1:0] buoy_gain;
    logic [GAIN_W-1:0] drag_gain;
    logic [GAIN_W-1:0] vel_gain;
    logic [GAIN_W-1:0] k_gain;
    logic [OFFS_W-1:0] offset;
    logic [MAXD_W-1:0] max_delta;
    longint            tick_acc;
    piston_cmd_t       cmds_due[$];
    int                fails;

    function new();
      buoy_gain = BUOY_RST;
      drag_gain = DRAG_RST;
      vel_gain  = VELG_RST;
      k_gain    = KGN_RST;
      offset    = OFFS_RST;
      max_delta = MAXD_RST;
      tick_acc  = 0;
      fails     = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      case (idx)
        CFG_BUOYANCY_GAIN:   buoy_gain = data;
        CFG_DRAG_GAIN:       drag_gain = data;
        CFG_VELOCITY_GAIN:   vel_gain  = data;
        CFG_OVERALL_GAIN:    k_gain    = data;
        CFG_POSITION_OFFSET: offset    = data[OFFS_W-1:0];
        CFG_MAX_DELTA:       max_delta = data[MAXD_W-1:0];
        default: ;
      endcase
    endfunction

    // (a*b) >> sh, truncated, saturated at 2^40
    function logic [63:0] scaled_product(logic [63:0] a, logic [31:0] b, int sh);
      logic [127:0] p;
      p = (128'(a) * 128'(b)) >> sh;
      if (p >= (128'd1 << CAP_LOG))
        return 64'd1 << CAP_LOG;
      return p[63:0];
    endfunction

    function int pending();
      return cmds_due.size();
    endfunction

    function void note_tick(logic [111:0] word);
      logic signed [31:0] depth;
      logic signed [31:0] speed;
      logic signed [31:0] target;
      logic [15:0]        ticks;
      logic [63:0]        vmag, vv, dterm, kterm, smag, cmag;
      longint             s, cmd, sum, lim, total, outv;
      piston_cmd_t        c;
      depth  = word[31:0];
      speed  = word[63:32];
      ticks  = word[79:64];
      target = word[111:80];
      if (target <= 0) begin
        // set point not positive: zero command, accumulator held
        c.piston_target = '0;
        c.regulating    = 1'b0;
        cmds_due.push_back(c);
        return;
      end
      vmag  = (speed < 0) ? 64'(-longint'(speed)) : 64'(longint'(speed));
      vv    = scaled_product(vmag, vmag[31:0], FRAC_BITS);
      dterm = scaled_product(vv, drag_gain, FRAC_BITS);
      kterm = scaled_product(vmag, vel_gain, FRAC_BITS);
      s = longint'(scaled_product({48'd0, ticks}, buoy_gain, BUOY_SH));
      if (speed < 0)
        s = s - longint'(dterm + kterm);
      else
        s = s + longint'(dterm + kterm);
      s = s + longint'(depth) - longint'(target);
      smag = (s < 0) ? 64'(-s) : 64'(s);
      cmag = scaled_product(smag, k_gain, FRAC_BITS);
      cmd  = (s < 0) ? longint'(cmag) : -longint'(cmag);
      // step only taken while it stays inside the window
      sum = tick_acc + cmd;
      if (((sum < 0) ? -sum : sum) < (longint'(STEP_LIMIT) <<< FRAC_BITS))
        tick_acc = sum;
      lim = longint'(max_delta) <<< FRAC_BITS;
      if (tick_acc > lim)
        tick_acc = lim;
      else if (tick_acc < -lim)
        tick_acc = -lim;
      total = tick_acc + (longint'(offset) <<< FRAC_BITS);
      if (total <= 0) begin
        outv = 0;
      end else begin
        outv = (total + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (outv > 65535)
          outv = 65535;
      end
      c.piston_target = 16'(outv);
      c.regulating    = 1'b1;
      cmds_due.push_back(c);
    endfunction

    function void check_cmd(logic [15:0] piston_target, logic regulating);
      piston_cmd_t c;
      if (cmds_due.size() == 0) begin
        $error("piston command with none owed: piston_target %0d regulating %0b",
               piston_target, regulating);
        fails++;
        return;
      end
      c = cmds_due.pop_front();
      if (piston_target !== c.piston_target) begin
        $error("piston_target expected %0d actual %0d", c.piston_target, piston_target);
        fails++;
      end
      if (regulating !== c.regulating) begin
        $error("regulating expected %0b actual %0b", c.regulating, regulating);
        fails++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [111:0]         s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [GAIN_W-1:0]    cfg_data_i;

  piston_cmd_board board;
  int              burst_left;
  int              stall_left = 0;
  drain_mode_e     stall_mode = DRAIN_FREE;
  logic [31:0]     stall_pat  = '0;

  depth_buoyancy_piston_regulator_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // result side: stall mode is picked at random per stretch, free-running stretches included
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = drain_mode_e'($urandom_range(0, 3));
      stall_pat  = $urandom;
      stall_left = 48;
    end
    stall_left = stall_left - 1;
    case (stall_mode)
      DRAIN_FREE:    m_axis_tready = 1'b1;
      DRAIN_PATTERN: m_axis_tready = stall_pat[stall_left % 32];
      DRAIN_SLOW:    m_axis_tready = ($urandom_range(0, 3) == 0);
      default:       m_axis_tready = 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_cmd(m_axis_tdata, m_axis_tuser);
  end

  // log-spread magnitudes so small and large values both show up
  function automatic logic [31:0] spread_u32();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] spread_s32();
    logic [31:0] m;
    m = $urandom >> $urandom_range(1, 31);
    return ($urandom_range(0, 1) != 0) ? -m : m;
  endfunction

  function automatic logic [111:0] pack_tick(logic [31:0] depth, logic [31:0] speed,
                                             logic [15:0] ticks, logic [31:0] target);
    return {target, ticks, speed, depth};
  endfunction

  // mostly a plausible tick near the set point, some disabled, some pure noise
  function automatic logic [111:0] random_tick();
    logic [31:0] t;
    logic [31:0] target;
    int          pick;
    pick = $urandom_range(0, 15);
    if (pick == 0)
      return {32'($urandom), 16'($urandom), 32'($urandom), 32'($urandom)};
    t = $urandom >> $urandom_range(1, 31);
    if (pick == 1)
      target = -t;
    else
      target = (t == 0) ? 32'd1 : t;
    return pack_tick(target + spread_s32(), spread_s32(), 16'($urandom_range(0, 65535)),
                     target);
  endfunction

  task automatic push_word(input logic [111:0] word);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_tick(word);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_tick(input logic [31:0] depth, input logic [31:0] speed,
                           input logic [15:0] ticks, input logic [31:0] target);
    push_word(pack_tick(depth, speed, ticks, target));
  endtask

  task automatic send_random(input int count);
    repeat (count) push_word(random_tick());
  endtask

  // stop sending and wait for every owed command
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic cfg_randomize();
    cfg_write(CFG_BUOYANCY_GAIN, spread_u32());
    cfg_write(CFG_DRAG_GAIN, spread_u32());
    cfg_write(CFG_VELOCITY_GAIN, spread_u32());
    cfg_write(CFG_OVERALL_GAIN, spread_u32());
    cfg_write(CFG_POSITION_OFFSET, 32'($urandom_range(0, 65535)));
    cfg_write(CFG_MAX_DELTA, 32'($urandom_range(0, 32767) >> $urandom_range(0, 14)));
  endtask

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    board         = new();
    burst_left    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // default gains: set point edges, field extremes, saturated products
    send_tick(32'(5 * 65536), 32'd0, 16'd1040, 32'(5 * 65536));
    send_tick(32'd0, 32'd0, 16'd0, 32'd0);
    send_tick(32'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 32'h8000_0000);
    send_tick(32'h8000_0000, 32'h8000_0000, 16'd0, 32'd1);       // huge step, never taken
    send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF);
    send_tick(32'(10 * 65536), 32'h0000_1000, 16'd500, 32'(12 * 65536));
    send_tick(32'(10 * 65536), 32'hFFFF_F000, 16'd500, 32'(12 * 65536));
    send_tick(32'(3 * 65536), 32'hFFFF_FFFF, 16'd0, 32'(3 * 65536));
    send_random(150);
    drain();

    // unit gain on depth error only: exact half ticks for rounding
    cfg_write(CFG_BUOYANCY_GAIN, 32'd0);
    cfg_write(CFG_DRAG_GAIN, 32'd0);
    cfg_write(CFG_VELOCITY_GAIN, 32'd0);
    cfg_write(CFG_OVERALL_GAIN, 32'd65536);
    cfg_write(CFG_POSITION_OFFSET, 32'd0);
    cfg_write(CFG_MAX_DELTA, 32'd0);
    send_tick(32'd0, 32'd0, 16'd0, 32'd1);                        // clamp pins accumulator at zero
    drain();
    cfg_write(CFG_MAX_DELTA, 32'd32767);
    send_tick(32'd0, 32'd0, 16'd0, 32'h0000_8000);                // +0.5 tick rounds up
    send_tick(32'h0001_0001, 32'd0, 16'd0, 32'd1);                // negative sum gives zero
    send_tick(32'(1 - 199 * 65536), 32'd0, 16'd0, 32'd1);         // lands just inside the window
    send_tick(32'(1 - 5 * 65536), 32'd0, 16'd0, 32'd1);           // step rejected
    send_random(60);
    drain();

    // every gain at its top, output pinned at the top code
    cfg_write(CFG_BUOYANCY_GAIN, 32'hFFFF_FFFF);
    cfg_write(CFG_DRAG_GAIN, 32'hFFFF_FFFF);
    cfg_write(CFG_VELOCITY_GAIN, 32'hFFFF_FFFF);
    cfg_write(CFG_OVERALL_GAIN, 32'hFFFF_FFFF);
    cfg_write(CFG_POSITION_OFFSET, 32'd65535);
    send_tick(32'd0, 32'd0, 16'hFFFF, 32'd1);
    send_random(80);
    drain();

    // unmapped slots must leave the settings alone
    cfg_write(CFG_SPARE_A, $urandom);
    cfg_write(CFG_SPARE_B, $urandom);
    repeat (3) begin
      cfg_randomize();
      send_random(70);
      drain();
    end

    // back to defaults for the tail
    cfg_write(CFG_BUOYANCY_GAIN, BUOY_RST);
    cfg_write(CFG_DRAG_GAIN, DRAG_RST);
    cfg_write(CFG_VELOCITY_GAIN, VELG_RST);
    cfg_write(CFG_OVERALL_GAIN, KGN_RST);
    cfg_write(CFG_POSITION_OFFSET, 32'(OFFS_RST));
    cfg_write(CFG_MAX_DELTA, 32'(MAXD_RST));
    send_random(100);
    drain();

    // room for a stray late result to show up
    repeat (40) @(posedge clk_i);
    if (board.fails == 0 && board.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
